@@ design/rcid_pkg.sv @@
`timescale 1ns / 1ps

package rcid_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;
  // queue entries plus the compute stage plus the output register
  localparam int INFLIGHT_MAX  = QUEUE_DEPTH + 2;

  localparam int CFG_W     = 11;
  localparam int MIN_WIDTH = 2;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

  localparam int NCH   = 3;
  localparam int ERR_W = 11;

  localparam logic [7:0] CUBE_OFFSET = 8'd2;
  localparam logic [7:0] IDX_LOW     = 8'd2;
  localparam logic [7:0] IDX_HIGH    = 8'd253;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [2:0] lvl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic clear;
    logic first;
    logic last;
    logic top_row;
  } flags_t;

  localparam err_t SAT_HIGH = 11'sh3FF;
  localparam err_t SAT_LOW  = 11'sh400;

  // smallest value that reaches level k+1 (v*n1/255 >= k+1)
  localparam logic [7:0] THR_5 [5] = '{8'd51, 8'd102, 8'd153, 8'd204, 8'd255};
  localparam logic [7:0] THR_6 [6] = '{8'd43, 8'd85, 8'd128, 8'd170, 8'd213, 8'd255};
  // level values 255*k/n1, truncated
  localparam logic [7:0] LVL_5 [6] = '{8'd0, 8'd51, 8'd102, 8'd153, 8'd204, 8'd255};
  localparam logic [7:0] LVL_6 [7] = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212, 8'd255};

  function automatic err_t sat11(logic signed [11:0] s);
    if (s > 12'sd1023) begin
      return SAT_HIGH;
    end
    if (s < -12'sd1024) begin
      return SAT_LOW;
    end
    return s[ERR_W-1:0];
  endfunction

  function automatic lvl_t quant5(err_t v);
    lvl_t q;
    q = '0;
    for (int k = 0; k < 5; k++) begin
      if (v >= $signed({3'b000, THR_5[k]})) begin
        q = q + 3'd1;
      end
    end
    return q;
  endfunction

  function automatic lvl_t quant6(err_t v);
    lvl_t q;
    q = '0;
    for (int k = 0; k < 6; k++) begin
      if (v >= $signed({3'b000, THR_6[k]})) begin
        q = q + 3'd1;
      end
    end
    return q;
  endfunction

  function automatic logic [7:0] level5(lvl_t q);
    return (q >= 3'd5) ? LVL_5[5] : LVL_5[q];
  endfunction

  function automatic logic [7:0] level6(lvl_t q);
    return (q >= 3'd6) ? LVL_6[6] : LVL_6[q];
  endfunction

  // divide by 16, truncating toward zero
  function automatic err_t div16(logic signed [13:0] x);
    logic signed [13:0] b;
    logic signed [13:0] s;
    b = x + (x[13] ? 14'sd15 : 14'sd0);
    s = b >>> 4;
    return s[ERR_W-1:0];
  endfunction

endpackage

@@ design/rcid_pix_if.sv @@
`timescale 1ns / 1ps

interface rcid_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       first_of_image;

  modport source (output valid, output red, output green, output blue,
                  output first_of_image, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input first_of_image, output ready);
endinterface

@@ design/rcid_idx_if.sv @@
`timescale 1ns / 1ps

interface rcid_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (output valid, output color_index, input ready);
  modport sink   (input valid, input color_index, output ready);
endinterface

@@ design/rcid_cfg_if.sv @@
`timescale 1ns / 1ps

interface rcid_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rcid_pkg::CFG_W-1:0]   image_width;

  modport source (output valid, output image_width, input ready);
  modport sink   (input valid, input image_width, output ready);
endinterface

@@ design/rcid_ram.sv @@
`timescale 1ns / 1ps

module rcid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/rcid_fifo.sv @@
`timescale 1ns / 1ps

module rcid_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ design/rcid_front.sv @@
`timescale 1ns / 1ps

module rcid_front #(
  parameter int MAX_WIDTH = rcid_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rcid_pkg::pix_t             in_pix,
  input  logic                       in_first_of_image,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rcid_pkg::CFG_W-1:0] cfg_width,
  output logic                       push_valid,
  input  logic                       push_ready,
  output rcid_pkg::pix_t             push_pix,
  output rcid_pkg::flags_t           push_flags,
  output logic [$clog2(MAX_WIDTH)-1:0] push_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > rcid_pkg::CFG_W) ? CW + 1 : rcid_pkg::CFG_W;

  logic [rcid_pkg::CFG_W-1:0] width_r;
  logic [CW-1:0]              col_r, col_nxt;
  logic                       top_row_r, top_row_nxt;
  logic [WW-1:0]              w_ext, w_clamp, w_m1;
  logic [CW-1:0]              last_col;
  logic [CW-1:0]              c;
  logic                       top, last, accept;

  assign cfg_ready = 1'b1;

  // clamp the configured width into [2, MAX_WIDTH]
  always_comb begin
    w_ext = WW'(width_r);
    if (w_ext < WW'(rcid_pkg::MIN_WIDTH)) begin
      w_clamp = WW'(rcid_pkg::MIN_WIDTH);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    w_m1     = w_clamp - 1'b1;
    last_col = w_m1[CW-1:0];
  end

  always_comb begin
    c           = in_first_of_image ? '0 : col_r;
    top         = in_first_of_image ? 1'b1 : top_row_r;
    last        = (c >= last_col);
    col_nxt     = last ? '0 : c + 1'b1;
    top_row_nxt = last ? 1'b0 : top;
  end

  assign accept     = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_pix   = in_pix;
  assign push_col   = c;

  always_comb begin
    push_flags.clear   = in_first_of_image;
    push_flags.first   = (c == '0);
    push_flags.last    = last;
    push_flags.top_row = top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rcid_pkg::WIDTH_RESET;
      col_r     <= '0;
      top_row_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        width_r <= cfg_width;
      end
      if (accept) begin
        col_r     <= col_nxt;
        top_row_r <= top_row_nxt;
      end
    end
  end

endmodule

@@ design/rcid_back.sv @@
`timescale 1ns / 1ps

module rcid_back #(
  parameter int MAX_WIDTH = rcid_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  rcid_pkg::pix_t               pop_pix,
  input  rcid_pkg::flags_t             pop_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0] pop_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_index
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWD = rcid_pkg::ERR_W;
  localparam int EW  = rcid_pkg::NCH * EWD;

  // compute stage
  logic                 s_valid_r;
  rcid_pkg::pix_t       s_pix_r;
  rcid_pkg::flags_t     s_flags_r;
  logic [CW-1:0]        s_col_r;
  logic                 byp_hit_r;
  logic [EW-1:0]        byp_data_r;
  logic [EW-1:0]        ram_q;

  // diffusion state
  rcid_pkg::err_t       rc_r  [rcid_pkg::NCH];
  rcid_pkg::err_t       pbl_r [rcid_pkg::NCH];
  rcid_pkg::err_t       pbh_r [rcid_pkg::NCH];
  rcid_pkg::err_t       rc_nxt  [rcid_pkg::NCH];
  rcid_pkg::err_t       pbl_nxt [rcid_pkg::NCH];
  rcid_pkg::err_t       pbh_nxt [rcid_pkg::NCH];

  // deferred write of the last column's entry
  logic                 tail_pend_r;
  logic [CW-1:0]        tail_addr_r;
  logic [EW-1:0]        tail_data_r;

  logic                 out_valid_r;
  logic [7:0]           out_index_r;

  logic                 s_fire, pop;
  logic                 wr_en;
  logic [CW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;
  logic [EW-1:0]        below_word, left_word, here_word;
  logic [7:0]           idx;

  assign s_fire    = s_valid_r && (!out_valid_r || out_ready);
  assign pop_ready = !s_valid_r || s_fire;
  assign pop       = pop_valid && pop_ready;

  assign below_word = s_flags_r.top_row ? '0 : (byp_hit_r ? byp_data_r : ram_q);

  always_comb begin
    logic [7:0]           pv [rcid_pkg::NCH];
    rcid_pkg::err_t       rc_eff, pbh_eff, below, v, e, t7, t5, t3, t1;
    logic signed [11:0]   sum, e12;
    logic signed [13:0]   e14;
    rcid_pkg::lvl_t       q [rcid_pkg::NCH];
    logic [7:0]           lv;
    pv[0] = s_pix_r.red;
    pv[1] = s_pix_r.green;
    pv[2] = s_pix_r.blue;
    left_word = '0;
    here_word = '0;
    for (int ch = 0; ch < rcid_pkg::NCH; ch++) begin
      rc_eff  = s_flags_r.clear ? '0 : rc_r[ch];
      pbh_eff = s_flags_r.clear ? '0 : pbh_r[ch];
      below   = below_word[ch*EWD +: EWD];
      sum     = $signed({4'b0000, pv[ch]}) + 12'(rc_eff) + 12'(below);
      v       = rcid_pkg::sat11(sum);
      // green has seven levels, red and blue six
      if (ch == 1) begin
        q[ch] = rcid_pkg::quant6(v);
        lv    = rcid_pkg::level6(q[ch]);
      end else begin
        q[ch] = rcid_pkg::quant5(v);
        lv    = rcid_pkg::level5(q[ch]);
      end
      e12 = 12'(v) - $signed({4'b0000, lv});
      e   = e12[EWD-1:0];
      e14 = 14'(e);
      t7  = rcid_pkg::div16(e14 * 14'sd7);
      t5  = rcid_pkg::div16(e14 * 14'sd5);
      t3  = rcid_pkg::div16(e14 * 14'sd3);
      t1  = rcid_pkg::div16(e14);
      left_word[ch*EWD +: EWD] = pbl_r[ch] + t3;
      here_word[ch*EWD +: EWD] = pbh_eff + t5;
      rc_nxt[ch]  = s_flags_r.last ? '0 : t7;
      pbl_nxt[ch] = s_flags_r.last ? '0 : pbh_eff + t5;
      pbh_nxt[ch] = s_flags_r.last ? '0 : t1;
    end
    idx = ((8'(q[0]) * 8'd7) + 8'(q[1])) * 8'd6 + 8'(q[2]) + rcid_pkg::CUBE_OFFSET;
  end

  // one write a cycle: the row-below-left entry, or the deferred tail entry
  // (the item after a row's last pixel starts a row and writes nothing)
  always_comb begin
    if (tail_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = tail_addr_r;
      wr_data = tail_data_r;
    end else begin
      wr_en   = s_fire && !s_flags_r.first;
      wr_addr = s_col_r - 1'b1;
      wr_data = left_word;
    end
  end

  rcid_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (pop),
    .raddr (pop_col),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      tail_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      byp_hit_r   <= 1'b0;
      for (int ch = 0; ch < rcid_pkg::NCH; ch++) begin
        rc_r[ch]  <= '0;
        pbl_r[ch] <= '0;
        pbh_r[ch] <= '0;
      end
    end else begin
      if (pop_ready) begin
        s_valid_r <= pop_valid;
      end
      if (pop) begin
        byp_hit_r <= wr_en && (wr_addr == pop_col);
      end
      tail_pend_r <= s_fire && s_flags_r.last;
      if (!out_valid_r || out_ready) begin
        out_valid_r <= s_valid_r;
      end
      if (s_fire) begin
        for (int ch = 0; ch < rcid_pkg::NCH; ch++) begin
          rc_r[ch]  <= rc_nxt[ch];
          pbl_r[ch] <= pbl_nxt[ch];
          pbh_r[ch] <= pbh_nxt[ch];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s_pix_r    <= pop_pix;
      s_flags_r  <= pop_flags;
      s_col_r    <= pop_col;
      byp_data_r <= wr_data;
    end
    if (s_fire) begin
      tail_addr_r <= s_col_r;
      tail_data_r <= here_word;
      out_index_r <= idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;

endmodule

@@ design/rgb_to_cube_index_dither.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Item
// -------  ---  ------------  ------------------------------------------------
// in_ch    in   valid/ready   red, green, blue (8b), first_of_image (1b)
// out_ch   out  valid/ready   color_index (8b), one per input pixel
// cfg_ch   in   ready high    image_width (11b), pixels per row
//
// One pixel per clock unless the output stalls; the right-hand error loops through the
// compute stage. After input accept the item is registered in the queue, then moves into
// the compute stage (error memory read), then into the output register.
// Synchronous active-low reset clears control and diffusion state; the error memory is
// never cleared, since the first row of an image does not read it.
// A stalled output holds the compute stage, the queue then fills and in_ch.ready drops.

module rgb_to_cube_index_dither #(
  parameter int MAX_WIDTH = rcid_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  rcid_pix_if.sink       in_ch,
  rcid_idx_if.source     out_ch,
  rcid_cfg_if.sink       cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(rcid_pkg::flags_t) + $bits(rcid_pkg::pix_t);

  rcid_pkg::pix_t   in_pix;
  rcid_pkg::pix_t   push_pix, pop_pix;
  rcid_pkg::flags_t push_flags, pop_flags;
  logic [CW-1:0]    push_col, pop_col;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]    pop_data;

  always_comb begin
    in_pix.red   = in_ch.red;
    in_pix.green = in_ch.green;
    in_pix.blue  = in_ch.blue;
  end

  // classify: column, row edges, first row, new image
  rcid_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_pix            (in_pix),
    .in_first_of_image (in_ch.first_of_image),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_width         (cfg_ch.image_width),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_pix          (push_pix),
    .push_flags        (push_flags),
    .push_col          (push_col)
  );

  // short queue between the front and the compute side
  rcid_fifo #(
    .W     (QW),
    .DEPTH (rcid_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_col, push_flags, push_pix}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_col, pop_flags, pop_pix} = pop_data;

  // quantize, diffuse the error, hold the row-below errors in memory
  rcid_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_pix   (pop_pix),
    .pop_flags (pop_flags),
    .pop_col   (pop_col),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.color_index)
  );

endmodule

@@ design/rcid_checker.sv @@
`timescale 1ns / 1ps

module rcid_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_index
);

  localparam int OW = $clog2(rcid_pkg::INFLIGHT_MAX + 2);

  logic [OW-1:0] outstanding_r, outstanding_nxt;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    outstanding_nxt = outstanding_r;
    if (in_acc && !out_acc) begin
      outstanding_nxt = outstanding_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding_nxt = outstanding_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outstanding_r != '0)
    else $error("result without a pending pixel");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= OW'(rcid_pkg::INFLIGHT_MAX))
    else $error("more pixels in flight than the pipeline holds");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index >= rcid_pkg::IDX_LOW && out_index <= rcid_pkg::IDX_HIGH)
    else $error("color index outside the cube");

endmodule

bind rgb_to_cube_index_dither rcid_checker u_rcid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.color_index)
);

@@ tb/sv/dither_index_checker.sv @@
`timescale 1ns / 1ps

module dither_index_checker (
  input  logic clk,
  input  logic rst_n,
  rcid_pix_if  pix,
  rcid_idx_if  idx,
  rcid_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);

  localparam int DEPTH      = rcid_pkg::MAX_WIDTH_DEF;
  localparam int FULL_SCALE = 255;
  localparam int LEVELS [3] = '{6, 7, 6};

  // diffusion state, updated in step with accepted pixels
  int                         below_err [DEPTH][3];
  int                         carry_right [3];
  int                         pend_left [3];
  int                         pend_here [3];
  int                         col;
  bit                         top_row;
  logic [rcid_pkg::CFG_W-1:0] width_reg;

  logic [7:0]                 expected_indices [$];

  function automatic void clear_diffusion();
    for (int ch = 0; ch < rcid_pkg::NCH; ch++) begin
      carry_right[ch] = 0;
      pend_left[ch]   = 0;
      pend_here[ch]   = 0;
    end
    col     = 0;
    top_row = 1'b1;
  endfunction

  function automatic logic [7:0] predict_index(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic start);
    int   ew;
    int   c;
    int   n1;
    int   v;
    int   lvl;
    int   e;
    int   comp [3];
    int   q [3];
    int   sum;
    bit   at_first;
    bit   at_last;
    comp[0] = r;
    comp[1] = g;
    comp[2] = b;
    if (start) begin
      clear_diffusion();
    end
    ew = int'(width_reg);
    if (ew < rcid_pkg::MIN_WIDTH) begin
      ew = rcid_pkg::MIN_WIDTH;
    end
    if (ew > DEPTH) begin
      ew = DEPTH;
    end
    c        = (col >= DEPTH) ? DEPTH - 1 : col;
    at_first = (c == 0);
    at_last  = (c >= ew - 1);

    for (int ch = 0; ch < rcid_pkg::NCH; ch++) begin
      n1 = LEVELS[ch] - 1;
      v  = comp[ch] + carry_right[ch];
      if (!top_row) begin
        v += below_err[c][ch];
      end
      if (v > int'(rcid_pkg::SAT_HIGH)) begin
        v = int'(rcid_pkg::SAT_HIGH);
      end
      if (v < int'(rcid_pkg::SAT_LOW)) begin
        v = int'(rcid_pkg::SAT_LOW);
      end
      q[ch] = v * n1 / FULL_SCALE;
      if (q[ch] > n1) begin
        q[ch] = n1;
      end
      if (q[ch] < 0) begin
        q[ch] = 0;
      end
      lvl = FULL_SCALE * q[ch] / n1;
      e   = v - lvl;

      carry_right[ch] = at_last ? 0 : e * 7 / 16;
      if (at_first) begin
        pend_left[ch] = pend_here[ch] + e * 5 / 16;
        pend_here[ch] = e / 16;
      end else begin
        below_err[c - 1][ch] = pend_left[ch] + e * 3 / 16;
        if (at_last) begin
          below_err[c][ch] = pend_here[ch] + e * 5 / 16;
          pend_left[ch]    = 0;
          pend_here[ch]    = 0;
        end else begin
          pend_left[ch] = pend_here[ch] + e * 5 / 16;
          pend_here[ch] = e / 16;
        end
      end
    end

    if (at_last) begin
      col     = 0;
      top_row = 1'b0;
    end else begin
      col = c + 1;
    end
    sum = (q[0] * 7 + q[1]) * 6 + q[2] + int'(rcid_pkg::CUBE_OFFSET);
    return sum[7:0];
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      expected_indices.delete();
      clear_diffusion();
      width_reg = rcid_pkg::WIDTH_RESET;
      mismatches <= 0;
      checked    <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        width_reg = cfg.image_width;
      end
      // compare before pushing: a result never belongs to a pixel of the same edge
      if (idx.valid && idx.ready) begin
        if (expected_indices.size() == 0) begin
          $display("%0t: unexpected color index: expected none, actual %0d",
                   $time, idx.color_index);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_indices.pop_front();
          checked <= checked + 1;
          if (want !== idx.color_index) begin
            $display("%0t: color index mismatch: expected %0d, actual %0d",
                     $time, want, idx.color_index);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (pix.valid && pix.ready) begin
        expected_indices.push_back(predict_index(pix.red, pix.green, pix.blue,
                                                 pix.first_of_image));
      end
    end
    outstanding <= expected_indices.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 660;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int WIDE_ITEMS   = 120;
  // corner values of a channel: rails, one off the rails, level thresholds
  localparam logic [7:0] EDGE_VALS [8] = '{8'd0, 8'd255, 8'd1, 8'd254,
                                           8'd128, 8'd43, 8'd42, 8'd213};

  logic clk;
  logic rst_n;

  int   send_idle   = 0;
  int   recv_idle   = 0;
  int   cycles      = 0;
  int   mismatches;
  int   outstanding;
  int   checked;
  int   sent         = 0;
  int   images       = 0;
  int   width_writes = 0;
  int   edge_pos     = 0;

  // stimulus-side view of the raster position, used only to keep every
  // read of the error row inside the columns written since reset
  int   eff_width;
  int   col_pos;
  int   hw_col;
  bit   top_row;

  rcid_pix_if pix_ch ();
  rcid_idx_if idx_ch ();
  rcid_cfg_if cfg_ch ();

  rgb_to_cube_index_dither uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (idx_ch),
    .cfg_ch (cfg_ch)
  );

  dither_index_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_ch),
    .idx         (idx_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // stall the result side at the current rate
  always @(posedge clk) begin
    idx_ch.ready <= ($urandom_range(99, 0) >= recv_idle);
  end

  function automatic int effective_width(input logic [rcid_pkg::CFG_W-1:0] w);
    if (w < rcid_pkg::MIN_WIDTH) begin
      return rcid_pkg::MIN_WIDTH;
    end
    if (w > rcid_pkg::MAX_WIDTH_DEF) begin
      return rcid_pkg::MAX_WIDTH_DEF;
    end
    return int'(w);
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(7, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // Drive one pixel and hold it until accepted; track the raster position
  // the same way the block steps through its row.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic start);
    int c;
    while ($urandom_range(99, 0) < send_idle) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid          <= 1'b1;
    pix_ch.red            <= r;
    pix_ch.green          <= g;
    pix_ch.blue           <= b;
    pix_ch.first_of_image <= start;
    do @(posedge clk); while (!pix_ch.ready);

    if (start) begin
      col_pos = 0;
      top_row = 1'b1;
      images++;
    end
    c = col_pos;
    if (c >= eff_width - 1) begin
      // last column: the row writes its own column and the one to the left
      if (c > hw_col) begin
        hw_col = c;
      end
      col_pos = 0;
      top_row = 1'b0;
    end else begin
      if (c > 0 && c - 1 > hw_col) begin
        hw_col = c - 1;
      end
      col_pos = c + 1;
    end
    sent++;
  endtask

  // Walk the corner table so that each channel meets both rails and the thresholds.
  task automatic send_edge_run(input int count, input bit open_image);
    for (int i = 0; i < count; i++) begin
      send_pixel(EDGE_VALS[edge_pos % 8], EDGE_VALS[(edge_pos * 3 + 1) % 8],
                 EDGE_VALS[(edge_pos * 5 + 2) % 8], open_image && (i == 0));
      edge_pos++;
    end
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (rcid_pkg::INFLIGHT_MAX + 4) @(posedge clk);
  endtask

  task automatic write_width(input logic [rcid_pkg::CFG_W-1:0] w);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.image_width <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    eff_width = effective_width(w);
    width_writes++;
  endtask

  initial begin
    logic [rcid_pkg::CFG_W-1:0] w;
    int                         ew;
    int                         len;
    int                         pick;
    int                         target;
    bit                         open_image;

    rst_n                 = 1'b0;
    pix_ch.valid          = 1'b0;
    pix_ch.red            = '0;
    pix_ch.green          = '0;
    pix_ch.blue           = '0;
    pix_ch.first_of_image = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.image_width    = '0;
    eff_width             = effective_width(rcid_pkg::WIDTH_RESET);
    col_pos               = 0;
    hw_col                = -1;
    top_row               = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed part ----------------
    send_idle = 19;
    recv_idle = 77;

    // straight out of reset at the reset width, then a new image mid-row
    send_edge_run(1, 1'b0);
    send_edge_run(1, 1'b1);

    // width zero acts as two: two short rows
    drain();
    write_width('0);
    send_edge_run(4, 1'b1);

    // width five: two full rows plus most of a third
    drain();
    write_width(rcid_pkg::CFG_W'(5));
    send_edge_run(14, 1'b1);

    // shrink mid-row to one (acts as two): the column beyond the new end
    // closes the row, then a full narrow row follows
    drain();
    write_width(rcid_pkg::CFG_W'(1));
    send_edge_run(3, 1'b0);

    // ---------------- random part ----------------
    // three stall regimes: sender light and receiver heavy, swapped, none
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 19 : (mode == 1) ? 77 : 0;
      recv_idle = (mode == 0) ? 77 : (mode == 1) ? 19 : 0;
      target    = sent + RANDOM_ITEMS / 3;
      while (sent < target) begin
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
          case ($urandom_range(5, 0))
            0: w = rcid_pkg::CFG_W'(0);
            1: w = rcid_pkg::CFG_W'(1);
            2: w = rcid_pkg::CFG_W'(rcid_pkg::MAX_WIDTH_DEF);
            3: w = rcid_pkg::CFG_W'(rcid_pkg::MAX_WIDTH_DEF + 1);
            4: w = '1;
            default: w = rcid_pkg::CFG_W'($urandom_range(2047, 3));
          endcase
        end else if (pick < 80) begin
          w = rcid_pkg::CFG_W'($urandom_range(12, 2));
        end else begin
          w = rcid_pkg::CFG_W'($urandom_range(40, 13));
        end
        ew = effective_width(w);

        // continue the image only where every column the new width reads is written
        open_image = ($urandom_range(3, 0) == 0) ||
                     !(top_row || ((ew - 1 <= hw_col) && (col_pos <= hw_col)));
        drain();
        write_width(w);

        // wide settings get a short partial row
        len = (ew <= 40) ? $urandom_range(ew * 3, 1) : $urandom_range(40, 1);
        for (int i = 0; i < len; i++) begin
          send_pixel(random_level(), random_level(), random_level(),
                     (open_image && i == 0) || ($urandom_range(99, 0) == 0));
        end
      end
    end

    // one image at the widest setting: a long stretch of its first row
    drain();
    write_width('1);
    for (int i = 0; i < WIDE_ITEMS; i++) begin
      send_pixel(random_level(), random_level(), random_level(), i == 0);
    end

    drain();
    $display("Covered %0d pixels in %0d images over %0d width writes (0 to 2047),",
             sent, images, width_writes);
    $display("%0d indices checked, with both stall mixes and at full rate.", checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
